/* design/nll_pkg.sv */
// Package for the numeric literal lexer: scan modes, radix kinds, character
// codes and the scan-state and result structs. No dependencies.
package nll_pkg;

    localparam int unsigned MAX_FRACTION_DIGITS = 19;

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_ZERO = 3'd1;
    localparam logic [2:0] MODE_BIN  = 3'd2;
    localparam logic [2:0] MODE_OCT  = 3'd3;
    localparam logic [2:0] MODE_HEX  = 3'd4;
    localparam logic [2:0] MODE_DEC  = 3'd5;
    localparam logic [2:0] MODE_FRAC = 3'd6;

    localparam logic [1:0] KIND_DEC = 2'd0;
    localparam logic [1:0] KIND_BIN = 2'd1;
    localparam logic [1:0] KIND_OCT = 2'd2;
    localparam logic [1:0] KIND_HEX = 2'd3;

    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_1      = 8'h31;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_UB     = 8'h42;
    localparam logic [7:0] CH_LB     = 8'h62;
    localparam logic [7:0] CH_UO     = 8'h4F;
    localparam logic [7:0] CH_LO     = 8'h6F;
    localparam logic [7:0] CH_UX     = 8'h58;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [3:0] HEX_TEN   = 4'hA;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] acc;
        logic [63:0] facc;
        logic [4:0]  fcnt;
    } t_scan;

    typedef struct packed {
        logic [63:0] int_value;
        logic        is_fractional;
        logic [63:0] fraction_digits;
        logic [4:0]  fraction_count;
        logic [1:0]  radix_kind;
    } t_result;

endpackage

/* design/nll_if.sv */
// Channel interfaces for the numeric literal lexer: character in, result out.
// Valid/ready handshake; depends on nothing.
interface nll_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface nll_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] int_value;
    logic        is_fractional;
    logic [63:0] fraction_digits;
    logic [4:0]  fraction_count;
    logic [1:0]  radix_kind;

    modport source (output valid, output int_value, output is_fractional,
                    output fraction_digits, output fraction_count,
                    output radix_kind, input ready);
    modport sink   (input valid, input int_value, input is_fractional,
                    input fraction_digits, input fraction_count,
                    input radix_kind, output ready);
endinterface

/* design/nll_step.sv */
// Next-state and result logic for one character of the literal scanner.
// Depends on nll_pkg.
module nll_step (
    input  nll_pkg::t_scan   i_cur,
    input  logic [7:0]       i_ch,
    output nll_pkg::t_scan   o_nxt,
    output logic             o_emit,
    output nll_pkg::t_result o_res
);

    logic        is_dec;
    logic        is_bin;
    logic        is_oct;
    logic        is_lhex;
    logic        is_uhex;
    logic [3:0]  dval;
    logic [3:0]  hval;
    logic [63:0] acc_x10;
    logic [63:0] facc_x10;
    logic        frac_room;
    logic        fin;
    logic [1:0]  fin_kind;
    logic        fin_frac;

    always_comb begin
        is_dec  = (i_ch >= nll_pkg::CH_0) && (i_ch <= nll_pkg::CH_9);
        is_bin  = (i_ch == nll_pkg::CH_0) || (i_ch == nll_pkg::CH_1);
        is_oct  = (i_ch >= nll_pkg::CH_0) && (i_ch <= nll_pkg::CH_7);
        is_lhex = (i_ch >= nll_pkg::CH_LA) && (i_ch <= nll_pkg::CH_LF);
        is_uhex = (i_ch >= nll_pkg::CH_UA) && (i_ch <= nll_pkg::CH_UF);
        dval    = 4'(i_ch - nll_pkg::CH_0);
        if (is_lhex) begin
            hval = 4'(i_ch - nll_pkg::CH_LA) + nll_pkg::HEX_TEN;
        end else if (is_uhex) begin
            hval = 4'(i_ch - nll_pkg::CH_UA) + nll_pkg::HEX_TEN;
        end else begin
            hval = dval;
        end
        acc_x10   = (i_cur.acc << 3) + (i_cur.acc << 1);
        facc_x10  = (i_cur.facc << 3) + (i_cur.facc << 1);
        frac_room = i_cur.fcnt < 5'(nll_pkg::MAX_FRACTION_DIGITS);
    end

    always_comb begin
        o_nxt    = i_cur;
        fin      = 1'b0;
        fin_kind = nll_pkg::KIND_DEC;
        fin_frac = 1'b0;
        unique case (i_cur.mode)
            nll_pkg::MODE_IDLE: begin
                o_nxt.acc  = '0;
                o_nxt.facc = '0;
                o_nxt.fcnt = '0;
                if (i_ch == nll_pkg::CH_0) begin
                    o_nxt.mode = nll_pkg::MODE_ZERO;
                end else if (is_dec) begin
                    o_nxt.acc  = {60'd0, dval};
                    o_nxt.mode = nll_pkg::MODE_DEC;
                end else if (i_ch == nll_pkg::CH_DOT) begin
                    o_nxt.mode = nll_pkg::MODE_FRAC;
                end else begin
                    fin = 1'b1;
                end
            end
            nll_pkg::MODE_ZERO: begin
                if (i_ch == nll_pkg::CH_LB || i_ch == nll_pkg::CH_UB) begin
                    o_nxt.mode = nll_pkg::MODE_BIN;
                end else if (i_ch == nll_pkg::CH_LO || i_ch == nll_pkg::CH_UO) begin
                    o_nxt.mode = nll_pkg::MODE_OCT;
                end else if (i_ch == nll_pkg::CH_LX || i_ch == nll_pkg::CH_UX) begin
                    o_nxt.mode = nll_pkg::MODE_HEX;
                end else if (i_ch == nll_pkg::CH_DOT) begin
                    o_nxt.mode = nll_pkg::MODE_FRAC;
                end else begin
                    fin = 1'b1;
                end
            end
            nll_pkg::MODE_BIN: begin
                if (is_bin) begin
                    o_nxt.acc = {i_cur.acc[62:0], dval[0]};
                end else begin
                    fin      = 1'b1;
                    fin_kind = nll_pkg::KIND_BIN;
                end
            end
            nll_pkg::MODE_OCT: begin
                if (is_oct) begin
                    o_nxt.acc = {i_cur.acc[60:0], dval[2:0]};
                end else begin
                    fin      = 1'b1;
                    fin_kind = nll_pkg::KIND_OCT;
                end
            end
            nll_pkg::MODE_HEX: begin
                if (is_dec || is_lhex || is_uhex) begin
                    o_nxt.acc = {i_cur.acc[59:0], hval};
                end else begin
                    fin      = 1'b1;
                    fin_kind = nll_pkg::KIND_HEX;
                end
            end
            nll_pkg::MODE_DEC: begin
                if (is_dec) begin
                    o_nxt.acc = acc_x10 + {60'd0, dval};
                end else if (i_ch == nll_pkg::CH_DOT) begin
                    o_nxt.mode = nll_pkg::MODE_FRAC;
                end else begin
                    fin = 1'b1;
                end
            end
            nll_pkg::MODE_FRAC: begin
                if (is_dec) begin
                    if (frac_room) begin
                        o_nxt.facc = facc_x10 + {60'd0, dval};
                        o_nxt.fcnt = i_cur.fcnt + 5'd1;
                    end
                end else begin
                    fin      = 1'b1;
                    fin_frac = 1'b1;
                end
            end
            default: begin
                // bad mode code: back to idle, no result
                o_nxt.mode = nll_pkg::MODE_IDLE;
                o_nxt.acc  = '0;
                o_nxt.facc = '0;
                o_nxt.fcnt = '0;
            end
        endcase

        if (fin) begin
            o_nxt.mode = nll_pkg::MODE_IDLE;
            o_nxt.acc  = '0;
            o_nxt.facc = '0;
            o_nxt.fcnt = '0;
        end

        o_emit                = fin;
        o_res.int_value       = (i_cur.mode == nll_pkg::MODE_IDLE) ? 64'd0 : i_cur.acc;
        o_res.is_fractional   = fin_frac;
        o_res.fraction_digits = fin_frac ? i_cur.facc : 64'd0;
        o_res.fraction_count  = fin_frac ? i_cur.fcnt : 5'd0;
        o_res.radix_kind      = fin_kind;
    end

endmodule

/* design/numeric_literal_lexer_core.sv */
// Numeric literal lexer: one character per transfer in; one result transfer
// out when a literal ends. Takes one character a cycle, sustained, whenever
// the result side is not stalled: a character goes into an input register,
// passes the combinational scan logic (one 64-bit shift or times-ten add)
// and, once the output register is free, a finished literal's result is
// registered there from the scan of its terminating character. The
// terminating character only ends the literal and must be sent again to
// start the next literal. Fraction digits beyond 19 are dropped. Depends on
// nll_pkg, nll_if and nll_step.
module numeric_literal_lexer_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    nll_in_if.sink         i_in,
    nll_out_if.source      o_out
);

    logic             r_in_valid;
    logic [7:0]       r_ch;
    nll_pkg::t_scan   r_scan;
    logic             r_out_valid;
    nll_pkg::t_result r_res;

    nll_pkg::t_scan   n_scan;
    nll_pkg::t_result step_res;
    logic             step_emit;
    logic             out_free;
    logic             stage_fire;

    nll_step u_step (
        .i_cur  (r_scan),
        .i_ch   (r_ch),
        .o_nxt  (n_scan),
        .o_emit (step_emit),
        .o_res  (step_res)
    );

    assign out_free   = !r_out_valid || o_out.ready;
    assign stage_fire = r_in_valid && (!step_emit || out_free);
    assign i_in.ready = !r_in_valid || stage_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_scan      <= '{mode: nll_pkg::MODE_IDLE, acc: '0, facc: '0, fcnt: '0};
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (stage_fire) begin
                r_scan <= n_scan;
            end
            if (stage_fire && step_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_ch <= i_in.ch;
        end
        if (stage_fire && step_emit) begin
            r_res <= step_res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.int_value       = r_res.int_value;
    assign o_out.is_fractional   = r_res.is_fractional;
    assign o_out.fraction_digits = r_res.fraction_digits;
    assign o_out.fraction_count  = r_res.fraction_count;
    assign o_out.radix_kind      = r_res.radix_kind;

endmodule

/* sim/nll_scan_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the numeric literal lexer: watches both channels, rescans every
// accepted character and compares each result transfer in order.
// Depends on nll_pkg and nll_if.
module nll_scan_checker
    import nll_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    nll_in_if    i_in_mon,
    nll_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);

    logic [2:0]  scan_mode;
    logic [63:0] int_acc;
    logic [63:0] frac_acc;
    logic [4:0]  frac_cnt;
    t_result     literal_q [$];
    int          fails;

    function automatic bit is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic void clear_scan();
        scan_mode = MODE_IDLE;
        int_acc   = '0;
        frac_acc  = '0;
        frac_cnt  = '0;
    endfunction

    function automatic t_result close_literal(input logic [1:0] kind, input logic frac);
        t_result r;
        r.int_value       = int_acc;
        r.is_fractional   = frac;
        r.fraction_digits = frac ? frac_acc : 64'd0;
        r.fraction_count  = frac ? frac_cnt : 5'd0;
        r.radix_kind      = kind;
        clear_scan();
        return r;
    endfunction

    // Returns 1 when the character ends the literal (character not consumed).
    function automatic bit scan_char(input logic [7:0] c, output t_result r);
        bit done;
        done = 1'b0;
        r    = '0;
        case (scan_mode)
            MODE_IDLE: begin
                clear_scan();
                if (c == CH_0) begin
                    scan_mode = MODE_ZERO;
                end else if (is_digit(c)) begin
                    int_acc   = 64'(c - CH_0);
                    scan_mode = MODE_DEC;
                end else if (c == CH_DOT) begin
                    scan_mode = MODE_FRAC;
                end else begin
                    r    = close_literal(KIND_DEC, 1'b0);
                    done = 1'b1;
                end
            end
            MODE_ZERO: begin
                if (c == CH_LB || c == CH_UB) begin
                    scan_mode = MODE_BIN;
                end else if (c == CH_LO || c == CH_UO) begin
                    scan_mode = MODE_OCT;
                end else if (c == CH_LX || c == CH_UX) begin
                    scan_mode = MODE_HEX;
                end else if (c == CH_DOT) begin
                    scan_mode = MODE_FRAC;
                end else begin
                    r    = close_literal(KIND_DEC, 1'b0);
                    done = 1'b1;
                end
            end
            MODE_BIN: begin
                if (c == CH_0 || c == CH_1) begin
                    int_acc = (int_acc << 1) | 64'(c - CH_0);
                end else begin
                    r    = close_literal(KIND_BIN, 1'b0);
                    done = 1'b1;
                end
            end
            MODE_OCT: begin
                if (c >= CH_0 && c <= CH_7) begin
                    int_acc = (int_acc << 3) | 64'(c - CH_0);
                end else begin
                    r    = close_literal(KIND_OCT, 1'b0);
                    done = 1'b1;
                end
            end
            MODE_HEX: begin
                if (is_digit(c)) begin
                    int_acc = (int_acc << 4) | 64'(c - CH_0);
                end else if (c >= CH_LA && c <= CH_LF) begin
                    int_acc = (int_acc << 4) | (64'(c - CH_LA) + 64'(HEX_TEN));
                end else if (c >= CH_UA && c <= CH_UF) begin
                    int_acc = (int_acc << 4) | (64'(c - CH_UA) + 64'(HEX_TEN));
                end else begin
                    r    = close_literal(KIND_HEX, 1'b0);
                    done = 1'b1;
                end
            end
            MODE_DEC: begin
                if (is_digit(c)) begin
                    int_acc = int_acc * 64'd10 + 64'(c - CH_0);
                end else if (c == CH_DOT) begin
                    scan_mode = MODE_FRAC;
                end else begin
                    r    = close_literal(KIND_DEC, 1'b0);
                    done = 1'b1;
                end
            end
            MODE_FRAC: begin
                if (is_digit(c)) begin
                    if (frac_cnt < MAX_FRACTION_DIGITS) begin
                        frac_acc = frac_acc * 64'd10 + 64'(c - CH_0);
                        frac_cnt = frac_cnt + 5'd1;
                    end
                end else begin
                    r    = close_literal(KIND_DEC, 1'b1);
                    done = 1'b1;
                end
            end
            default: begin
                clear_scan();
            end
        endcase
        return done;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result predicted;
        t_result got;
        t_result want;
        bit      bad;
        if (!i_rst_n) begin
            clear_scan();
            literal_q.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                if (scan_char(i_in_mon.ch, predicted)) begin
                    literal_q.push_back(predicted);
                end
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.int_value       = i_out_mon.int_value;
                got.is_fractional   = i_out_mon.is_fractional;
                got.fraction_digits = i_out_mon.fraction_digits;
                got.fraction_count  = i_out_mon.fraction_count;
                got.radix_kind      = i_out_mon.radix_kind;
                if (literal_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("unexpected result transfer: int=%h frac=%0d fd=%0d fc=%0d radix=%0d",
                                 got.int_value, got.is_fractional, got.fraction_digits,
                                 got.fraction_count, got.radix_kind);
                    end
                end else begin
                    want = literal_q.pop_front();
                    bad  = (got.int_value       !== want.int_value)
                        || (got.is_fractional   !== want.is_fractional)
                        || (got.fraction_digits !== want.fraction_digits)
                        || (got.fraction_count  !== want.fraction_count)
                        || (got.radix_kind      !== want.radix_kind);
                    if (bad) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("result mismatch: expected int=%h frac=%0d fd=%0d fc=%0d radix=%0d",
                                     want.int_value, want.is_fractional, want.fraction_digits,
                                     want.fraction_count, want.radix_kind);
                            $display("                 actual   int=%h frac=%0d fd=%0d fc=%0d radix=%0d",
                                     got.int_value, got.is_fractional, got.fraction_digits,
                                     got.fraction_count, got.radix_kind);
                        end
                    end
                end
            end
        end
        o_pending    <= literal_q.size();
        o_fail_count <= fails;
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Top of the numeric literal lexer testbench: clock, reset, character stimulus
// and result back-pressure. Depends on nll_pkg, nll_if and nll_scan_checker.
module tb_top;
    import nll_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 5000;

    typedef enum {
        LIT_DEC, LIT_BIN, LIT_OCT, LIT_HEX, LIT_FRAC, LIT_DOT_FRAC,
        LIT_ZERO_FRAC, LIT_BARE_PREFIX, LIT_ZERO_LEAD, LIT_NOISE
    } t_lit;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_req;
    int   sent;

    nll_in_if  in_if ();
    nll_out_if out_if ();

    numeric_literal_lexer_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    nll_scan_checker u_scan_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_if),
        .i_out_mon    (out_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stall, or one long hold-off on request
    initial begin : result_sink
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.ch    <= c;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_digits(input int base, input int n);
        int v;
        repeat (n) begin
            v = $urandom_range(0, base - 1);
            if (v < 10) begin
                send_char(CH_0 + 8'(v));
            end else begin
                send_char(($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(v - 10));
            end
        end
    endtask

    function automatic logic [7:0] prefix_ch(input t_lit kind);
        bit up;
        up = $urandom_range(0, 1);
        case (kind)
            LIT_BIN: return up ? CH_UB : CH_LB;
            LIT_OCT: return up ? CH_UO : CH_LO;
            default: return up ? CH_UX : CH_LX;
        endcase
    endfunction

    function automatic logic [7:0] stop_ch();
        case ($urandom_range(0, 7))
            0:       return 8'h20;
            1:       return 8'h2C;
            2:       return 8'h3B;
            3:       return 8'h29;
            4:       return 8'h67;
            5:       return 8'h5A;
            6:       return 8'h00;
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    function automatic t_lit pick_lit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return LIT_DEC;
        if (r < 32) return LIT_BIN;
        if (r < 44) return LIT_OCT;
        if (r < 58) return LIT_HEX;
        if (r < 72) return LIT_FRAC;
        if (r < 79) return LIT_DOT_FRAC;
        if (r < 86) return LIT_ZERO_FRAC;
        if (r < 90) return LIT_BARE_PREFIX;
        if (r < 94) return LIT_ZERO_LEAD;
        return LIT_NOISE;
    endfunction

    task automatic send_literal(input t_lit kind);
        bit         long_lit;
        logic [7:0] stop;
        long_lit = ($urandom_range(0, 9) == 0);
        case (kind)
            LIT_DEC: begin
                send_char(CH_0 + 8'($urandom_range(1, 9)));
                send_digits(10, long_lit ? $urandom_range(19, 25) : $urandom_range(0, 5));
            end
            LIT_BIN: begin
                send_char(CH_0);
                send_char(prefix_ch(kind));
                send_digits(2, long_lit ? $urandom_range(60, 72) : $urandom_range(1, 8));
            end
            LIT_OCT: begin
                send_char(CH_0);
                send_char(prefix_ch(kind));
                send_digits(8, long_lit ? $urandom_range(20, 26) : $urandom_range(1, 6));
            end
            LIT_HEX: begin
                send_char(CH_0);
                send_char(prefix_ch(kind));
                send_digits(16, long_lit ? $urandom_range(15, 20) : $urandom_range(1, 6));
            end
            LIT_FRAC: begin
                send_char(CH_0 + 8'($urandom_range(1, 9)));
                send_digits(10, $urandom_range(0, 3));
                send_char(CH_DOT);
                send_digits(10, long_lit ? $urandom_range(18, 25) : $urandom_range(0, 6));
            end
            LIT_DOT_FRAC: begin
                send_char(CH_DOT);
                send_digits(10, long_lit ? $urandom_range(18, 25) : $urandom_range(0, 6));
            end
            LIT_ZERO_FRAC: begin
                send_char(CH_0);
                send_char(CH_DOT);
                send_digits(10, long_lit ? $urandom_range(18, 25) : $urandom_range(0, 6));
            end
            LIT_BARE_PREFIX: begin
                send_char(CH_0);
                case ($urandom_range(0, 2))
                    0:       send_char(prefix_ch(LIT_BIN));
                    1:       send_char(prefix_ch(LIT_OCT));
                    default: send_char(prefix_ch(LIT_HEX));
                endcase
            end
            LIT_ZERO_LEAD: begin
                send_char(CH_0);
                send_digits(10, $urandom_range(1, 3));
            end
            default: begin
                repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
            end
        endcase
        if (kind != LIT_NOISE) begin
            stop = stop_ch();
            send_char(stop);
            // at random, the ending character also goes back in as the caller would
            if ($urandom_range(0, 1)) send_char(stop);
        end
    endtask

    task automatic wait_drained(input int limit);
        int n;
        n = 0;
        @(posedge i_clk);
        while (pending != 0 && n < limit) begin
            @(posedge i_clk);
            n++;
        end
    endtask

    initial begin : stimulus
        logic [7:0] directed_q [$];
        int         target;
        bit         paused;
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.ch       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        sent           = 0;
        paused         = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_q = '{CH_0, CH_LB, CH_1, 8'h2C, 8'h2C,
                       CH_0, CH_UO, CH_7, 8'h20,
                       CH_0, CH_UX, CH_LA, CH_UF, 8'h29,
                       CH_9, CH_DOT, 8'h35, CH_DOT,
                       CH_DOT, 8'hFF, 8'hFF,
                       CH_0, CH_1, CH_1, 8'h00,
                       CH_0, CH_LX, 8'h00};
        foreach (directed_q[k]) send_char(directed_q[k]);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            target = sent + RANDOM_ITEMS / 4;
            if (phase == 0) hold_req = 1'b1;
            while (sent < target) begin
                if (phase == 1 && !paused && sent >= target - 80) begin
                    in_if.valid <= 1'b0;
                    wait_drained(DRAIN_LIMIT);
                    paused = 1'b1;
                end
                send_literal(pick_lit());
            end
        end

        in_if.valid <= 1'b0;
        wait_drained(DRAIN_LIMIT);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
design/nll_pkg.sv
design/nll_if.sv
design/nll_step.sv
design/numeric_literal_lexer_core.sv
sim/nll_scan_checker.sv
sim/tb_top.sv
